### rtl/sgre_pkg.sv
// shared constants, types and the rice parameter function of the gap coder
package sgre_pkg;

    localparam int POS_BITS  = 32;
    localparam int ALPHABET  = 256;
    localparam int SYM_BITS  = 8;
    localparam int ADDR_BITS = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int K_BITS    = 5;
    localparam int K_MAX     = 31;
    localparam int Q_BITS    = 32;
    localparam int R_BITS    = 31;
    localparam int OUT_DEPTH = 4;
    localparam int PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);

    typedef logic [POS_BITS-1:0]  t_pos;
    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic {
        CMD_COUNT  = 1'b0,
        CMD_ENCODE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic [Q_BITS-1:0]   quotient;
        logic [R_BITS-1:0]   remainder;
        logic [K_BITS-1:0]   rice_k;
        logic                first_in_page;
        logic                overflow;
    } t_result;

    // largest k with count <= total >> k, zero when count is zero or not below total
    function automatic logic [K_BITS-1:0] pick_k(t_pos total, t_pos count);
        logic [K_BITS-1:0] k;
        k = '0;
        if ((count != '0) && (count < total)) begin
            for (int i = 1; i <= K_MAX; i++) begin
                if (count <= (total >> i)) begin
                    k = K_BITS'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

### rtl/sgre_in_if.sv
// request channel into the gap coder: command and source byte
interface sgre_in_if import sgre_pkg::*; ();
    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [SYM_BITS-1:0] byte_value;

    modport source (output valid, command, byte_value, input ready);
    modport sink   (input valid, command, byte_value, output ready);
endinterface

### rtl/sgre_out_if.sv
// codeword channel out of the gap coder
interface sgre_out_if import sgre_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SYM_BITS-1:0] symbol;
    logic [Q_BITS-1:0]   quotient;
    logic [R_BITS-1:0]   remainder;
    logic [K_BITS-1:0]   rice_k;
    logic                first_in_page;
    logic                overflow;

    modport source (output valid, symbol, quotient, remainder, rice_k, first_in_page,
                    overflow, input ready);
    modport sink   (input valid, symbol, quotient, remainder, rice_k, first_in_page,
                    overflow, output ready);
endinterface

### rtl/sgre_out_fifo.sv
// small result queue that drives the codeword channel
module sgre_out_fifo import sgre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_result             i_data,
    output logic [CNT_BITS-1:0] o_count,
    sgre_out_if.source          o_out
);

    t_result               r_mem [OUT_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count,  n_count;
    logic                  pop;
    t_result               head;

    assign pop  = (r_count != '0) && o_out.ready;
    assign head = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_count             = r_count;
    assign o_out.valid         = (r_count != '0);
    assign o_out.symbol        = head.symbol;
    assign o_out.quotient      = head.quotient;
    assign o_out.remainder     = head.remainder;
    assign o_out.rice_k        = head.rice_k;
    assign o_out.first_in_page = head.first_in_page;
    assign o_out.overflow      = head.overflow;

endmodule

### rtl/symbol_gap_rice_encoder_unit.sv
// top level of the per-symbol gap coder with golomb-rice split
//
// usage: requests arrive on i_in (command, byte_value). a count request adds
// the byte to the histogram and to the byte total and gives no codeword. an
// encode request gives one codeword on o_out: symbol, rice_k picked from the
// histogram, quotient and remainder of the gap since the symbol's last
// position (or the absolute position on first sight) and the sticky overflow
// flag. counters saturate instead of wrapping.
// throughput: one request per cycle while i_in.ready is high, mixed freely. the histogram
// and last-position tables are single-port-write memories read when the request
// is taken; the write of the previous request is forwarded for the same symbol.
// pipeline: memory read, update and k/gap stage, quotient/remainder stage into the
// output queue, after which the codeword is valid.
// reset: counters, overflow, seen flags and histogram valid bits clear in the
// reset cycle, so the block takes requests straight after reset; no sweep.
// stall: a 4-entry output queue absorbs codewords; i_in.ready drops only when
// queued plus in-flight codewords fill it, and nothing is lost.
module symbol_gap_rice_encoder_unit import sgre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgre_in_if.sink    i_in,
    sgre_out_if.source o_out
);

    // tables
    t_pos                r_cnt_mem [ALPHABET];
    t_pos                r_pos_mem [ALPHABET];
    t_pos                r_cnt_rd;
    t_pos                r_pos_rd;
    logic [ALPHABET-1:0] r_cnt_vld;
    logic [ALPHABET-1:0] r_seen;

    t_pos                r_total,    n_total;
    t_pos                r_position, n_position;
    logic                r_sat,      n_sat;

    // stage 1
    logic                r_s1_valid;
    logic                r_s1_live;
    t_cmd                r_s1_cmd;
    logic [SYM_BITS-1:0] r_s1_sym;

    // forwarding of the last write
    logic                r_fwd_cnt_en;
    t_addr               r_fwd_cnt_addr;
    t_pos                r_fwd_cnt_data;
    logic                r_fwd_pos_en;
    t_addr               r_fwd_pos_addr;
    t_pos                r_fwd_pos_data;

    // stage 2
    logic                r_s2_valid;
    logic [SYM_BITS-1:0] r_s2_sym;
    t_pos                r_s2_gap;
    logic [K_BITS-1:0]   r_s2_k;
    logic                r_s2_first;
    logic                r_s2_ovf;

    logic                accept;
    logic                in_live;
    t_addr               in_addr;
    t_addr               s1_addr;
    logic                do_count;
    logic                do_enc;
    t_pos                s1_count;
    t_pos                s1_last;
    t_pos                n_count;
    logic                cnt_at_max;
    logic                tot_at_max;
    logic                pos_at_max;
    logic                s1_first;
    t_pos                s1_gap;
    logic [K_BITS-1:0]   s1_k;
    logic [CNT_BITS-1:0] fifo_count;
    logic [CNT_BITS:0]   pending;
    t_result             s2_result;
    t_pos                s2_mask;

    assign accept  = i_in.valid && i_in.ready;
    assign in_live = ({1'b0, i_in.byte_value} < (SYM_BITS + 1)'(ALPHABET));
    assign in_addr = i_in.byte_value[ADDR_BITS-1:0];
    assign s1_addr = r_s1_sym[ADDR_BITS-1:0];

    // codewords queued or still in flight must fit in the output queue
    assign pending = (CNT_BITS + 1)'(fifo_count)
                   + (CNT_BITS + 1)'(r_s1_valid && (r_s1_cmd == CMD_ENCODE))
                   + (CNT_BITS + 1)'(r_s2_valid);
    assign i_in.ready = (pending < (CNT_BITS + 1)'(OUT_DEPTH));

    always_comb begin
        do_count = r_s1_valid && r_s1_live && (r_s1_cmd == CMD_COUNT);
        do_enc   = r_s1_valid && r_s1_live && (r_s1_cmd == CMD_ENCODE);

        // an entry never written reads as zero; the previous write wins over the
        // stale read data
        if (!r_cnt_vld[s1_addr]) begin
            s1_count = '0;
        end else if (r_fwd_cnt_en && (r_fwd_cnt_addr == s1_addr)) begin
            s1_count = r_fwd_cnt_data;
        end else begin
            s1_count = r_cnt_rd;
        end
        s1_last = (r_fwd_pos_en && (r_fwd_pos_addr == s1_addr)) ? r_fwd_pos_data
                                                                 : r_pos_rd;

        cnt_at_max = (s1_count == '1);
        tot_at_max = (r_total == '1);
        pos_at_max = (r_position == '1);
        n_count    = cnt_at_max ? s1_count : s1_count + 1'b1;

        s1_first = !r_seen[s1_addr];
        if (s1_first) begin
            s1_gap = r_position;
        end else if (r_position > s1_last) begin
            s1_gap = r_position - s1_last - 1'b1;
        end else begin
            s1_gap = '0;
        end
        s1_k = pick_k(r_total, s1_count);

        n_total    = r_total;
        n_position = r_position;
        n_sat      = r_sat;
        if (do_count) begin
            n_total = tot_at_max ? r_total : r_total + 1'b1;
            n_sat   = r_sat || cnt_at_max || tot_at_max;
        end
        if (do_enc) begin
            n_position = pos_at_max ? r_position : r_position + 1'b1;
            n_sat      = r_sat || pos_at_max;
        end
    end

    // table memories: registered read of the incoming symbol, written by stage 1
    always_ff @(posedge i_clk) begin
        if (do_count) begin
            r_cnt_mem[s1_addr] <= n_count;
        end
        r_cnt_rd <= r_cnt_mem[in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (do_enc) begin
            r_pos_mem[s1_addr] <= r_position;
        end
        r_pos_rd <= r_pos_mem[in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld    <= '0;
            r_seen       <= '0;
            r_total      <= '0;
            r_position   <= '0;
            r_sat        <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_fwd_cnt_en <= 1'b0;
            r_fwd_pos_en <= 1'b0;
        end else begin
            if (do_count) begin
                r_cnt_vld[s1_addr] <= 1'b1;
            end
            if (do_enc) begin
                r_seen[s1_addr] <= 1'b1;
            end
            r_total      <= n_total;
            r_position   <= n_position;
            r_sat        <= n_sat;
            r_s1_valid   <= accept;
            r_s2_valid   <= do_enc;
            r_fwd_cnt_en <= do_count;
            r_fwd_pos_en <= do_enc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_live      <= in_live;
        r_s1_cmd       <= i_in.command;
        r_s1_sym       <= i_in.byte_value;
        r_fwd_cnt_addr <= s1_addr;
        r_fwd_cnt_data <= n_count;
        r_fwd_pos_addr <= s1_addr;
        r_fwd_pos_data <= r_position;
        r_s2_sym       <= r_s1_sym;
        r_s2_gap       <= s1_gap;
        r_s2_k         <= s1_k;
        r_s2_first     <= s1_first;
        r_s2_ovf       <= n_sat;
    end

    // quotient and remainder split
    always_comb begin
        s2_mask                 = (t_pos'(1) << r_s2_k) - 1'b1;
        s2_result.symbol        = r_s2_sym;
        s2_result.quotient      = Q_BITS'(r_s2_gap >> r_s2_k);
        s2_result.remainder     = R_BITS'(r_s2_gap & s2_mask);
        s2_result.rice_k        = r_s2_k;
        s2_result.first_in_page = r_s2_first;
        s2_result.overflow      = r_s2_ovf;
    end

    sgre_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (s2_result),
        .o_count (fifo_count),
        .o_out   (o_out)
    );

endmodule

### bench/tb_symbol_gap_rice_encoder_unit.sv
// testbench for the per-symbol gap coder: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_symbol_gap_rice_encoder_unit;
    import sgre_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sgre_in_if  in_req ();
    sgre_out_if out_cw ();

    symbol_gap_rice_encoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_req),
        .o_out   (out_cw)
    );

    // predictor state
    t_pos    hist_count [ALPHABET];
    t_pos    last_pos [ALPHABET];
    bit      seen [ALPHABET];
    t_pos    bytes_counted;
    t_pos    next_position;
    bit      sticky_overflow;
    t_result pending_codewords [$];

    bit steady_flow;
    int mismatches;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_symbol_gap_rice_encoder_unit failed");
        $finish;
    end

    // mostly no pause, often a short one, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // largest shift with count still fitting under total, searched from the top
    function automatic logic [K_BITS-1:0] rice_k_for(t_pos total, t_pos count);
        logic [K_BITS-1:0] k;
        k = '0;
        if (count != '0 && count < total) begin
            for (int s = K_MAX; s >= 1; s--) begin
                if (k == '0 && (total >> s) >= count) begin
                    k = K_BITS'(s);
                end
            end
        end
        return k;
    endfunction

    task automatic count_byte(logic [SYM_BITS-1:0] b);
        if (hist_count[b] == '1) begin
            sticky_overflow = 1'b1;
        end else begin
            hist_count[b] = hist_count[b] + 1'b1;
        end
        if (bytes_counted == '1) begin
            sticky_overflow = 1'b1;
        end else begin
            bytes_counted = bytes_counted + 1'b1;
        end
    endtask

    task automatic code_symbol(logic [SYM_BITS-1:0] b);
        t_result cw;
        t_pos    gap;
        t_pos    pos;
        cw.symbol = b;
        cw.rice_k = rice_k_for(bytes_counted, hist_count[b]);
        pos = next_position;
        cw.first_in_page = !seen[b];
        if (!seen[b]) begin
            gap = pos;
        end else if (pos > last_pos[b]) begin
            gap = pos - last_pos[b] - 1'b1;
        end else begin
            gap = '0;
        end
        last_pos[b] = pos;
        seen[b] = 1'b1;
        if (next_position == '1) begin
            sticky_overflow = 1'b1;
        end else begin
            next_position = next_position + 1'b1;
        end
        cw.quotient  = Q_BITS'(gap >> cw.rice_k);
        cw.remainder = R_BITS'(gap & ((t_pos'(1) << cw.rice_k) - 1'b1));
        cw.overflow  = sticky_overflow;
        pending_codewords = {pending_codewords, cw};
    endtask

    task automatic send_request(t_cmd cmd, logic [SYM_BITS-1:0] b);
        int gap;
        gap = steady_flow ? 0 : pick_pause();
        @(negedge i_clk);
        if (gap > 0) begin
            in_req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_req.valid      = 1'b1;
        in_req.command    = cmd;
        in_req.byte_value = b;
        @(posedge i_clk);
        while (in_req.ready !== 1'b1) @(posedge i_clk);
        if (cmd == CMD_COUNT) begin
            count_byte(b);
        end else begin
            code_symbol(b);
        end
    endtask

    task automatic drop_request();
        @(negedge i_clk);
        in_req.valid = 1'b0;
    endtask

    task automatic drain_codewords();
        drop_request();
        while (pending_codewords.size() != 0) @(posedge i_clk);
    endtask

    // nothing counted yet: k stays zero, first sight, back-to-back repeat gives gap zero
    task automatic test_empty_histogram();
        send_request(CMD_ENCODE, 8'h00);
        send_request(CMD_ENCODE, 8'hFF);
        send_request(CMD_ENCODE, 8'h00);
        send_request(CMD_ENCODE, 8'h00);
        send_request(CMD_ENCODE, 8'hFF);
    endtask

    // only one symbol counted, so its count equals the total
    task automatic test_lone_symbol();
        repeat (3) send_request(CMD_COUNT, 8'hAA);
        send_request(CMD_ENCODE, 8'hAA);
    endtask

    // rare symbol gets a large k, common one k zero, uncounted one k zero
    task automatic test_rice_k_spread();
        send_request(CMD_COUNT, 8'h01);
        repeat (10) send_request(CMD_COUNT, 8'h80);
        send_request(CMD_ENCODE, 8'h01);
        send_request(CMD_ENCODE, 8'h80);
        send_request(CMD_ENCODE, 8'h55);
    endtask

    // sender holds off until every codeword is out
    task automatic test_sender_hold();
        drain_codewords();
        send_request(CMD_ENCODE, 8'hAA);
        drain_codewords();
    endtask

    task automatic test_random_stream(int n_items);
        logic [SYM_BITS-1:0] hot [8];
        logic [SYM_BITS-1:0] b;
        t_cmd                cmd;
        int                  pick;
        foreach (hot[j]) hot[j] = SYM_BITS'($urandom_range(255));
        steady_flow = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i == 120) begin
                steady_flow = 1'b0;
            end
            if (i == n_items / 2) begin
                drain_codewords();
            end
            // skewed symbol mix so k spreads out and repeats are common
            pick = $urandom_range(99);
            if (pick < 35) begin
                b = hot[0];
            end else if (pick < 60) begin
                b = hot[$urandom_range(7)];
            end else begin
                b = SYM_BITS'($urandom_range(255));
            end
            cmd = ($urandom_range(99) < 55) ? CMD_COUNT : CMD_ENCODE;
            send_request(cmd, b);
        end
        steady_flow = 1'b0;
        drop_request();
    endtask

    // sink side: random stalls unless the flow is steady
    initial begin : sink_ready
        int stall_left;
        stall_left = 0;
        out_cw.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_cw.ready = 1'b0;
            end else begin
                out_cw.ready = 1'b1;
                if (!steady_flow && $urandom_range(2) == 0) begin
                    stall_left = pick_pause();
                end
            end
        end
    end

    always @(posedge i_clk) begin : codeword_check
        t_result exp_cw;
        if (i_rst_n && out_cw.valid === 1'b1 && out_cw.ready === 1'b1) begin
            if (pending_codewords.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected codeword: sym %0h q %0d r %0d k %0d first %0b ovf %0b",
                             out_cw.symbol, out_cw.quotient, out_cw.remainder,
                             out_cw.rice_k, out_cw.first_in_page, out_cw.overflow);
                end
            end else begin
                exp_cw = pending_codewords.pop_front();
                if (out_cw.symbol !== exp_cw.symbol || out_cw.quotient !== exp_cw.quotient
                    || out_cw.remainder !== exp_cw.remainder || out_cw.rice_k !== exp_cw.rice_k
                    || out_cw.first_in_page !== exp_cw.first_in_page
                    || out_cw.overflow !== exp_cw.overflow) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("codeword mismatch: exp sym %0h q %0d r %0d k %0d first %0b ovf %0b",
                                 exp_cw.symbol, exp_cw.quotient, exp_cw.remainder,
                                 exp_cw.rice_k, exp_cw.first_in_page, exp_cw.overflow);
                        $display("                   got sym %0h q %0d r %0d k %0d first %0b ovf %0b",
                                 out_cw.symbol, out_cw.quotient, out_cw.remainder,
                                 out_cw.rice_k, out_cw.first_in_page, out_cw.overflow);
                    end
                end
            end
        end
    end

    initial begin : run_tests
        int waited;
        i_rst_n = 1'b0;
        in_req.valid = 1'b0;
        in_req.command = CMD_COUNT;
        in_req.byte_value = '0;
        steady_flow = 1'b0;
        mismatches = 0;
        bytes_counted = '0;
        next_position = '0;
        sticky_overflow = 1'b0;
        foreach (hist_count[j]) begin
            hist_count[j] = '0;
            last_pos[j] = '0;
            seen[j] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_histogram();
        test_lone_symbol();
        test_rice_k_spread();
        test_sender_hold();
        test_random_stream(625);

        waited = 0;
        while (pending_codewords.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_codewords.size() == 0) begin
            $display("tb_symbol_gap_rice_encoder_unit passed");
        end else begin
            $display("tb_symbol_gap_rice_encoder_unit failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sgre_pkg.sv
rtl/sgre_in_if.sv
rtl/sgre_out_if.sv
rtl/sgre_out_fifo.sv
rtl/symbol_gap_rice_encoder_unit.sv
bench/tb_symbol_gap_rice_encoder_unit.sv
